### rtl/core/suffixed_number_parser_assert.svh
// Assertion macros for the suffixed number parser.
// Included by the top level; needs no other file.
`ifndef SUFFIXED_NUMBER_PARSER_ASSERT_SVH
`define SUFFIXED_NUMBER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define SNP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("suffixed_number_parser: assertion failed");

// Next-cycle implication, disabled during reset
`define SNP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("suffixed_number_parser: assertion failed");

`endif

### rtl/core/snp_pkg.sv
// Shared types, character codes and helper functions for the suffixed number parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package snp_pkg;

   localparam int ValueW   = 64;
   localparam int CharW    = 8;
   localparam int PowerW   = 3;
   localparam int ShiftBin = 10;
   localparam int WideW    = ValueW + ShiftBin;
   localparam int Stages   = 6;   // largest suffix power

   // ASCII codes
   localparam logic [CharW-1:0] CharZero   = 8'h30;
   localparam logic [CharW-1:0] CharNine   = 8'h39;
   localparam logic [CharW-1:0] CharUpperA = 8'h41;
   localparam logic [CharW-1:0] CharUpperZ = 8'h5A;
   localparam logic [CharW-1:0] CaseOffset = 8'h20;
   localparam logic [CharW-1:0] CharKilo   = 8'h6B;
   localparam logic [CharW-1:0] CharMega   = 8'h6D;
   localparam logic [CharW-1:0] CharGiga   = 8'h67;
   localparam logic [CharW-1:0] CharTera   = 8'h74;
   localparam logic [CharW-1:0] CharPeta   = 8'h70;
   localparam logic [CharW-1:0] CharExa    = 8'h65;

   // Suffix powers
   localparam logic [PowerW-1:0] PowNone = 3'd0;
   localparam logic [PowerW-1:0] PowKilo = 3'd1;
   localparam logic [PowerW-1:0] PowMega = 3'd2;
   localparam logic [PowerW-1:0] PowGiga = 3'd3;
   localparam logic [PowerW-1:0] PowTera = 3'd4;
   localparam logic [PowerW-1:0] PowPeta = 3'd5;
   localparam logic [PowerW-1:0] PowExa  = 3'd6;

   // One item in flight through the scaling pipeline
   typedef struct packed {
      logic [ValueW-1:0] value;
      logic [PowerW-1:0] power;   // scale steps still to apply
      logic              err;
      logic              binary;  // 1: steps of 1024, 0: steps of 1000
   } snp_stage_type;

   function automatic logic is_digit(input logic [CharW-1:0] c);
      return (c >= CharZero) && (c <= CharNine);
   endfunction

   // Power of a suffix letter, either case; PowNone if not a suffix
   function automatic logic [PowerW-1:0] suffix_power_of(input logic [CharW-1:0] c);
      logic [CharW-1:0] lc;
      logic [PowerW-1:0] p;
      lc = ((c >= CharUpperA) && (c <= CharUpperZ)) ? c + CaseOffset : c;
      unique case (lc)
         CharKilo: p = PowKilo;
         CharMega: p = PowMega;
         CharGiga: p = PowGiga;
         CharTera: p = PowTera;
         CharPeta: p = PowPeta;
         CharExa:  p = PowExa;
         default:  p = PowNone;
      endcase
      return p;
   endfunction

   // One scale step: times 1024, or times 1000 as x*1024 - x*16 - x*8
   function automatic snp_stage_type scale_step(input snp_stage_type s);
      snp_stage_type    r;
      logic [WideW-1:0] base;
      logic [WideW-1:0] wide;
      r    = s;
      base = {{ShiftBin{1'b0}}, s.value};
      wide = s.binary ? (base << ShiftBin)
                      : (base << ShiftBin) - (base << 4) - (base << 3);
      if (s.err) begin
         r.power = PowNone;
         r.value = '0;
      end else if (s.power != PowNone) begin
         r.power = s.power - 3'd1;
         if (|wide[WideW-1:ValueW]) begin
            r.err   = 1'b1;
            r.power = PowNone;
            r.value = '0;
         end else begin
            r.value = wide[ValueW-1:0];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/core/suffixed_number_parser.sv
// Suffixed number parser top level: digit accumulator and suffix scaling pipeline.
// Depends on snp_pkg and suffixed_number_parser_assert.svh.
//
// Usage:
//   req_* carries one character per beat (tdata), tlast on the final
//   character of a string. Digits build a 64-bit value; a final k m g t p e
//   (either case) scales it by 1000^n, or by 1024^n when csr_wr_data = 1
//   was written. One rsp beat is produced per string: tdata = value,
//   tuser = error (value is 0 on error).
//   Pipeline: the final character enters an entry register and then
//   six scale stages, one scale step per stage.
//   Throughput: one character per cycle while req_tready is high, set by
//   the combinational multiply-by-ten accumulate.
//   Reset: accumulator and flags clear, pipeline empties, binary mode off.
//   Stalls: when rsp_tready is low, the pipeline stages fill up behind the
//   held result; req_tready drops only once every stage holds an item.
//   User must write configuration only while no string is in flight; unchecked.
`timescale 1ns / 1ps
`default_nettype none

`include "suffixed_number_parser_assert.svh"

module suffixed_number_parser (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // configuration
   input  wire logic                        csr_wr_en,
   input  wire logic                        csr_wr_data,   // binary_units
   // character stream
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [snp_pkg::CharW-1:0]   req_tdata,     // [7:0] character
   input  wire logic                        req_tlast,     // last
   // result stream
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [snp_pkg::ValueW-1:0]       rsp_tdata,     // [63:0] value
   output logic                             rsp_tuser      // [0] error
);
   import snp_pkg::*;

   logic                 binary_ff;
   logic [ValueW-1:0]    acc_ff, acc_in;
   logic                 bad_ff, bad_in;
   logic                 ovf_ff, ovf_in;
   snp_stage_type        stage_ff [0:Stages];
   snp_stage_type        stage_in;
   logic [Stages:0]      vld_ff;
   logic [Stages:0]      rdy;
   logic                 accept;
   logic                 digit;
   logic [3:0]           dval;
   logic [ValueW+3:0]    prod;
   logic [ValueW-1:0]    acc_dig;
   logic                 ovf_dig;
   logic [PowerW-1:0]    pow;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         binary_ff <= 1'b0;
      end else if (csr_wr_en) begin
         binary_ff <= csr_wr_data;
      end
   end

   // Ready chain: a stage takes a beat when empty or moving on
   assign rdy[Stages] = !vld_ff[Stages] || rsp_tready;
   for (genvar j = 0; j < Stages; j++) begin : g_rdy
      assign rdy[j] = !vld_ff[j] || rdy[j+1];
   end

   assign req_tready = rdy[0];
   assign accept     = req_tvalid && req_tready;

   // Digit step: acc*10 + d, overflow when the top bits are set
   always_comb begin
      digit   = is_digit(req_tdata);
      dval    = 4'(req_tdata - CharZero);
      prod    = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {{ValueW{1'b0}}, dval};
      ovf_dig = ovf_ff || (|prod[ValueW+3:ValueW]);
      acc_dig = (ovf_ff || ovf_dig) ? acc_ff : prod[ValueW-1:0];
      pow     = suffix_power_of(req_tdata);
   end

   // Parse state next value and the item entering the pipeline
   always_comb begin
      acc_in          = acc_ff;
      bad_in          = bad_ff;
      ovf_in          = ovf_ff;
      stage_in.binary = binary_ff;
      stage_in.power  = PowNone;
      stage_in.err    = 1'b0;
      stage_in.value  = acc_ff;
      if (digit) begin
         acc_in = acc_dig;
         ovf_in = ovf_dig;
         stage_in.value = acc_dig;
         stage_in.err   = bad_ff || ovf_dig;
      end else begin
         bad_in = 1'b1;
         stage_in.power = pow;
         stage_in.err   = bad_ff || ovf_ff || (pow == PowNone);
      end
      if (stage_in.err) begin
         stage_in.value = '0;
         stage_in.power = PowNone;
      end
      // a string end clears the parse state
      if (req_tlast) begin
         acc_in = '0;
         bad_in = 1'b0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         bad_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else if (accept) begin
         acc_ff <= acc_in;
         bad_ff <= bad_in;
         ovf_ff <= ovf_in;
      end
   end

   // Pipeline valid bits: the entry takes final characters only
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_tvalid && req_tlast;
         end
         for (int k = 0; k < Stages; k++) begin
            if (rdy[k+1]) begin
               vld_ff[k+1] <= vld_ff[k];
            end
         end
      end
   end

   // Pipeline data: entry item, then one power of the base per stage
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         stage_ff[0] <= stage_in;
      end
      for (int k = 0; k < Stages; k++) begin
         if (rdy[k+1]) begin
            stage_ff[k+1] <= scale_step(stage_ff[k]);
         end
      end
   end

   // Result beat
   assign rsp_tvalid = vld_ff[Stages];
   assign rsp_tdata  = stage_ff[Stages].value;
   assign rsp_tuser  = stage_ff[Stages].err;

   // Checks
   `SNP_ASSERT_IMP(a_err_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0)
   `SNP_ASSERT_IMP(a_all_scaled, clock, reset, vld_ff[Stages], stage_ff[Stages].power == PowNone)
   `SNP_ASSERT_NEXT(a_clear_on_end, clock, reset, accept && req_tlast,
                    (acc_ff == '0) && !bad_ff && !ovf_ff)

endmodule

`default_nettype wire

### tb/tb_suffixed_number_parser.sv
// Self-checking testbench for suffixed_number_parser: directed table, then random strings.
// Needs snp_pkg and the suffixed_number_parser top level; results checked by a built-in predictor.
`timescale 1ns / 1ps

module tb_suffixed_number_parser;
   import snp_pkg::*;

   localparam logic [ValueW-1:0] ValueMax   = '1;
   localparam int                CycleLimit = 400000;
   localparam int                DrainWait  = 12;
   localparam int                PhaseBeats = 200;
   localparam int                TotalBeats = 1200;

   typedef struct {
      logic [ValueW-1:0] value;
      logic              error;
   } parse_result_type;

   typedef struct {
      logic [CharW-1:0]  ch;
      logic              fin;
      bit                fixed;    // expectation typed in below
      logic [ValueW-1:0] value;
      logic              error;
   } dir_row_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic                csr_wr_data = 1'b0;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [CharW-1:0]    req_tdata   = '0;
   logic                req_tlast   = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [ValueW-1:0]   rsp_tdata;
   logic                rsp_tuser;

   // predictor state
   logic [ValueW-1:0]   digits_value = '0;
   logic [PowerW-1:0]   pend_power   = PowNone;
   bit                  saw_suffix   = 1'b0;
   bit                  malformed    = 1'b0;
   bit                  digits_over  = 1'b0;
   bit                  binary_mode  = 1'b0;

   parse_result_type    pending_results[$];
   dir_row_type         directed[$];
   logic [CharW-1:0]    string_buf[$];
   int                  failures    = 0;
   int                  cycle_count = 0;
   int                  sent_beats  = 0;
   int                  req_quiet   = 0;
   int                  rsp_quiet   = 0;

   suffixed_number_parser dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [7:0] character
      .req_tlast   (req_tlast),    // last
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [63:0] value
      .rsp_tuser   (rsp_tuser)     // [0] error
   );

   always #5 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb_suffixed_number_parser failed");
         $finish;
      end
   end

   // idle cycles before a beat; now and then a run of beats with none
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) quiet = $urandom_range(16, 64);
      return $urandom_range(0, 8);
   endfunction

   function automatic logic [PowerW-1:0] letter_power(input logic [CharW-1:0] c);
      logic [CharW-1:0] lc;
      lc = c;
      if (c >= CharUpperA && c <= CharUpperZ) lc = c + CaseOffset;
      case (lc)
         CharKilo: return PowKilo;
         CharMega: return PowMega;
         CharGiga: return PowGiga;
         CharTera: return PowTera;
         CharPeta: return PowPeta;
         CharExa:  return PowExa;
         default:  return PowNone;
      endcase
   endfunction

   function automatic bit is_dec(input logic [CharW-1:0] c);
      return c >= CharZero && c <= CharNine;
   endfunction

   function automatic void add_digit(input logic [CharW-1:0] c);
      logic [ValueW-1:0] d;
      d = ValueW'(c - CharZero);
      if (digits_over) return;
      if (digits_value > (ValueMax - d) / 10) digits_over = 1'b1;
      else digits_value = digits_value * 10 + d;
   endfunction

   // parse one character; a result only on the final one
   task automatic parse_char(input logic [CharW-1:0] c, input logic fin,
                             output bit produced, output parse_result_type res);
      logic [ValueW-1:0] v;
      bit                err;
      produced = 1'b0;
      res      = '{value: '0, error: 1'b0};
      if (!fin) begin
         if (is_dec(c)) add_digit(c);
         else malformed = 1'b1;
      end else begin
         if (is_dec(c)) begin
            add_digit(c);
         end else begin
            pend_power = letter_power(c);
            if (pend_power == PowNone) malformed = 1'b1;
            else saw_suffix = 1'b1;
         end
         v   = digits_value;
         err = malformed || digits_over;
         if (!err && v != 0 && saw_suffix) begin
            for (int i = 0; i < pend_power && !err; i++) begin
               if (binary_mode) begin
                  if (v > (ValueMax >> ShiftBin)) err = 1'b1;
                  else v = v << ShiftBin;
               end else begin
                  if (v > ValueMax / 1000) err = 1'b1;
                  else v = v * 1000;
               end
            end
         end
         produced  = 1'b1;
         res.value = err ? '0 : v;
         res.error = err;
         digits_value = '0;
         pend_power   = PowNone;
         saw_suffix   = 1'b0;
         malformed    = 1'b0;
         digits_over  = 1'b0;
      end
   endtask

   // drive one beat and record what it should produce
   task automatic send_beat(input logic [CharW-1:0] c, input logic fin, input bit fixed,
                            input logic [ValueW-1:0] fv, input logic fe);
      int               gap;
      bit               produced;
      parse_result_type res;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_beats++;
      parse_char(c, fin, produced, res);
      if (produced) begin
         if (fixed) res = '{value: fv, error: fe};
         pending_results.push_back(res);
      end
   endtask

   // register write once the pipeline has emptied
   task automatic write_mode(input logic mode);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      binary_mode = mode;
      csr_wr_en   <= 1'b0;
   endtask

   function automatic void add_row(input logic [CharW-1:0] c, input logic fin, input bit fixed,
                                   input logic [ValueW-1:0] v, input logic e);
      directed.push_back('{ch: c, fin: fin, fixed: fixed, value: v, error: e});
   endfunction

   function automatic void push_decimal(input logic [ValueW-1:0] v);
      int start;
      start = string_buf.size();
      if (v == 0) string_buf.push_back(CharZero);
      while (v != 0) begin
         string_buf.insert(start, CharZero + CharW'(v % 10));
         v = v / 10;
      end
   endfunction

   function automatic logic [CharW-1:0] any_letter();
      logic [CharW-1:0] letters[6];
      logic [CharW-1:0] c;
      letters = '{CharKilo, CharMega, CharGiga, CharTera, CharPeta, CharExa};
      c = letters[$urandom_range(0, 5)];
      if ($urandom_range(0, 1) == 1) c = c - CaseOffset;
      return c;
   endfunction

   function automatic logic [CharW-1:0] any_digit();
      return CharZero + CharW'($urandom_range(0, 9));
   endfunction

   // build one random string, mostly well formed, and send it
   task automatic emit_string();
      int               kind;
      int               n;
      int               ending;
      bit               zeros;
      logic [CharW-1:0] c;
      string_buf.delete();
      kind = $urandom_range(0, 99);
      if (kind < 90) begin
         case ($urandom_range(0, 5))
            0, 1, 2: begin
               n     = $urandom_range(1, 6);
               zeros = ($urandom_range(0, 7) == 0);
               repeat (n) string_buf.push_back(zeros ? CharZero : any_digit());
            end
            3: push_decimal({$urandom, $urandom} >> $urandom_range(0, 63));
            4: begin
               // straddle the digit overflow boundary
               push_decimal(ValueMax / 10);
               string_buf.push_back(any_digit());
               if ($urandom_range(0, 2) == 0) string_buf.push_back(any_digit());
            end
            default: push_decimal(ValueMax - $urandom_range(0, 30));
         endcase
         ending = $urandom_range(0, 9);
         if (ending == 9) begin
            string_buf.delete();
            string_buf.push_back(any_letter());
         end else if (ending >= 4) begin
            string_buf.push_back(any_letter());
         end
         if (kind >= 75) begin
            if ($urandom_range(0, 1) == 1) begin
               do c = CharW'($urandom_range(0, 255)); while (is_dec(c));
               string_buf.insert($urandom_range(0, string_buf.size() - 1), c);
            end else begin
               string_buf[string_buf.size() - 1] = CharW'($urandom_range(0, 255));
            end
         end
      end else begin
         n = $urandom_range(1, 6);
         repeat (n) string_buf.push_back(CharW'($urandom_range(0, 255)));
      end
      foreach (string_buf[i])
         send_beat(string_buf[i], i == string_buf.size() - 1, 1'b0, '0, 1'b0);
   endtask

   // result ready: random stalls between beats
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_quiet);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      parse_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result value %0d error %0d",
                     $time, rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.value) begin
               $display("%0t: value expected %0d actual %0d", $time, want.value, rsp_tdata);
               failures++;
            end
            if (rsp_tuser !== want.error) begin
               $display("%0t: error expected %0d actual %0d", $time, want.error, rsp_tuser);
               failures++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int phase_end;
      int phase;
      logic mode;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b0);

      // zero value, suffix alone, zero with suffix
      add_row(CharZero, 1'b1, 1'b1, '0, 1'b0);
      add_row(CharKilo, 1'b1, 1'b1, '0, 1'b0);
      add_row(CharZero, 1'b0, 1'b0, '0, 1'b0);
      add_row(CharExa - CaseOffset, 1'b1, 1'b1, '0, 1'b0);
      // plain scaling
      add_row("5", 1'b0, 1'b0, '0, 1'b0);
      add_row(CharKilo, 1'b1, 1'b0, '0, 1'b0);
      add_row("3", 1'b0, 1'b0, '0, 1'b0);
      add_row(CharMega - CaseOffset, 1'b1, 1'b0, '0, 1'b0);
      add_row("1", 1'b0, 1'b0, '0, 1'b0);
      add_row("6", 1'b0, 1'b0, '0, 1'b0);
      add_row(CharExa, 1'b1, 1'b0, '0, 1'b0);
      // unknown final character, extremes of the byte
      add_row("x", 1'b1, 1'b1, '0, 1'b1);
      add_row(8'hFF, 1'b1, 1'b1, '0, 1'b1);
      add_row(8'h00, 1'b1, 1'b1, '0, 1'b1);
      // non-digit and suffix before the end
      add_row("1", 1'b0, 1'b0, '0, 1'b0);
      add_row("a", 1'b0, 1'b0, '0, 1'b0);
      add_row("2", 1'b1, 1'b1, '0, 1'b1);
      add_row("7", 1'b0, 1'b0, '0, 1'b0);
      add_row(CharGiga, 1'b0, 1'b0, '0, 1'b0);
      add_row("1", 1'b1, 1'b1, '0, 1'b1);
      // product overflow: 99 times 1000^6
      add_row("9", 1'b0, 1'b0, '0, 1'b0);
      add_row("9", 1'b0, 1'b0, '0, 1'b0);
      add_row(CharExa, 1'b1, 1'b1, '0, 1'b1);
      foreach (directed[i])
         send_beat(directed[i].ch, directed[i].fin, directed[i].fixed,
                   directed[i].value, directed[i].error);

      // random phases, both unit modes
      phase_end = sent_beats;
      phase     = 0;
      while (sent_beats < TotalBeats) begin
         mode = (phase == 0) ? 1'b1 : (phase == 1) ? 1'b0 : 1'($urandom_range(0, 1));
         write_mode(mode);
         phase_end += PhaseBeats;
         while (sent_beats < phase_end) emit_string();
         phase++;
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
      if (failures == 0)
         $display("tb_suffixed_number_parser passed");
      else
         $display("tb_suffixed_number_parser failed");
      $finish;
   end

endmodule
